[src/lafp_pkg.sv]
// shared types and constants of the lifetime-aware first-fit packer
package lafp_pkg;

    // request kinds carried on the input tuser bit
    localparam logic OP_RESERVE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // fixed field widths of the stream payloads
    localparam int BYTES_W     = 32;
    localparam int ALIGN_W     = 5;
    localparam int OFFSET_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 72;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_START  = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_FETCH  = 7'b0010000,
        S_CALC   = 7'b0100000,
        S_TEST   = 7'b1000000
    } state_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic start_zero;
        logic scan_step;
        logic decide;
        logic fetch;
        logic calc;
        logic test_start;
        logic finish;
    } cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic clear_req;
        logic full;
        logic scan_done;
        logic j_more;
        logic skip;
        logic out_free;
    } sts_t;

endpackage

[src/lafp_ctrl.sv]
// sequencer of the packer: candidate walk and collision scan control
module lafp_ctrl import lafp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd,
    output logic finishing
);

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    assign s_tready  = (state_reg == S_IDLE) && !fin_reg;
    assign finishing = fin_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        if (fin_reg) begin
            // result waits for a free output slot
            if (sts.out_free) begin
                cmd.finish = 1'b1;
                fin_next   = 1'b0;
                state_next = S_IDLE;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd.load   = 1'b1;
                        state_next = S_START;
                    end
                end
                S_START: begin
                    if (sts.clear_req || sts.full) begin
                        fin_next = 1'b1;
                    end else begin
                        cmd.start_zero = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
                S_SCAN: begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_done) begin
                        state_next = S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    cmd.decide = 1'b1;
                    if (sts.j_more) begin
                        state_next = S_FETCH;
                    end else begin
                        fin_next = 1'b1;
                    end
                end
                S_FETCH: begin
                    cmd.fetch  = 1'b1;
                    state_next = S_CALC;
                end
                S_CALC: begin
                    cmd.calc   = 1'b1;
                    state_next = S_TEST;
                end
                S_TEST: begin
                    if (!sts.skip) begin
                        cmd.test_start = 1'b1;
                        state_next     = S_SCAN;
                    end else if (sts.j_more) begin
                        state_next = S_FETCH;
                    end else begin
                        fin_next = 1'b1;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/lafp_dp.sv]
// datapath of the packer: region table, candidate and collision logic, result register
module lafp_dp import lafp_pkg::*; #(
    parameter int MAX_REGIONS = 16,
    parameter int ADDR_BITS   = 32,
    parameter int PASS_BITS   = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CNT_W = IW + 1;
    localparam int CW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
    localparam int EW = CW + 1;
    localparam logic [EW-1:0] LIMIT = (EW'(1) << ADDR_BITS) - EW'(1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

    // region table
    logic [ADDR_BITS-1:0] mem_off   [MAX_REGIONS];
    logic [ADDR_BITS-1:0] mem_end   [MAX_REGIONS];
    logic [PASS_BITS-1:0] mem_first [MAX_REGIONS];
    logic [PASS_BITS-1:0] mem_last  [MAX_REGIONS];

    logic [ADDR_BITS-1:0] rd_off_reg, rd_end_reg;
    logic [PASS_BITS-1:0] rd_first_reg, rd_last_reg;

    // request registers
    logic                 clear_reg;
    logic [BYTES_W-1:0]   bytes_reg;
    logic [ALIGN_W-1:0]   alog_reg;
    logic [PASS_BITS-1:0] first_reg, last_reg;

    // control state of the datapath
    logic [CNT_W-1:0]     count_reg, k_reg, j_reg;
    logic                 pending_reg, coll_reg, found_reg, hit_j_reg;
    logic [CW-1:0]        cand_reg, best_reg;
    logic [EW-1:0]        cand_end_reg;
    logic [ADDR_BITS-1:0] size_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                 rd_en;
    logic [CNT_W-1:0]     rd_addr;
    logic                 life_hit, scan_hit, k_more;
    logic [CW-1:0]        mask, cand_calc, best_final;
    logic [EW-1:0]        total;
    logic                 ovf;
    logic [OFFSET_W-1:0]  res_off, res_hw;
    logic [STATUS_W-1:0]  res_st;

    // lifetime overlap against the entry just read
    assign life_hit = (rd_first_reg <= last_reg) && (first_reg <= rd_last_reg);
    assign scan_hit = life_hit && (cand_reg < CW'(rd_end_reg))
                    && (EW'(rd_off_reg) < cand_end_reg);
    assign k_more   = (k_reg < count_reg);

    // table read address
    assign rd_en   = (cmd.scan_step && k_more) || cmd.fetch;
    assign rd_addr = cmd.fetch ? j_reg : k_reg;

    // aligned end of the fetched region
    assign mask      = (CW'(1) << alog_reg) - CW'(1);
    assign cand_calc = (CW'(rd_end_reg) + mask) & ~mask;

    // final placement and range check
    assign best_final = found_reg ? best_reg : '0;
    assign total      = EW'(best_final) + EW'(bytes_reg);
    assign ovf        = (total > LIMIT);

    // table memory
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_off_reg   <= mem_off[rd_addr[IW-1:0]];
            rd_end_reg   <= mem_end[rd_addr[IW-1:0]];
            rd_first_reg <= mem_first[rd_addr[IW-1:0]];
            rd_last_reg  <= mem_last[rd_addr[IW-1:0]];
        end
        if (cmd.finish && !clear_reg && (count_reg < MAX_CNT) && !ovf) begin
            mem_off[count_reg[IW-1:0]]   <= best_final[ADDR_BITS-1:0];
            mem_end[count_reg[IW-1:0]]   <= total[ADDR_BITS-1:0];
            mem_first[count_reg[IW-1:0]] <= first_reg;
            mem_last[count_reg[IW-1:0]]  <= last_reg;
        end
    end

    // request capture and candidate registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clear_reg <= s_tuser;
            bytes_reg <= s_tdata[31:0];
            alog_reg  <= s_tdata[36:32];
            first_reg <= PASS_BITS'(s_tdata[44:37]);
            last_reg  <= PASS_BITS'(s_tdata[52:45]);
        end
        if (cmd.start_zero) begin
            cand_reg     <= '0;
            cand_end_reg <= EW'(bytes_reg);
        end
        if (cmd.calc) begin
            cand_reg  <= cand_calc;
            hit_j_reg <= life_hit;
        end
        if (cmd.test_start) begin
            cand_end_reg <= EW'(cand_reg) + EW'(bytes_reg);
        end
        if (cmd.decide && !coll_reg) begin
            best_reg <= cand_reg;
        end
    end

    // counters, flags and table size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            size_reg    <= '0;
            k_reg       <= '0;
            j_reg       <= '0;
            pending_reg <= 1'b0;
            coll_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            if (cmd.start_zero || cmd.test_start) begin
                k_reg       <= '0;
                pending_reg <= 1'b0;
                coll_reg    <= 1'b0;
            end
            if (cmd.start_zero) begin
                j_reg     <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                pending_reg <= k_more;
                if (k_more) begin
                    k_reg <= k_reg + CNT_W'(1);
                end
                if (pending_reg && scan_hit) begin
                    coll_reg <= 1'b1;
                end
            end
            if (cmd.decide && !coll_reg) begin
                found_reg <= 1'b1;
            end
            if (cmd.fetch) begin
                j_reg <= j_reg + CNT_W'(1);
            end
            if (cmd.finish) begin
                if (clear_reg) begin
                    count_reg <= '0;
                    size_reg  <= '0;
                end else if ((count_reg < MAX_CNT) && !ovf) begin
                    count_reg <= count_reg + CNT_W'(1);
                    if (total > EW'(size_reg)) begin
                        size_reg <= total[ADDR_BITS-1:0];
                    end
                end
            end
        end
    end

    // result fields
    always_comb begin
        res_off = '0;
        res_hw  = OFFSET_W'(size_reg);
        res_st  = ST_OK;
        if (clear_reg) begin
            res_hw = '0;
        end else if (count_reg >= MAX_CNT) begin
            res_st = ST_FULL;
        end else if (ovf) begin
            res_st = ST_OVERFLOW;
        end else begin
            res_off = best_final[OFFSET_W-1:0];
            if (total > EW'(size_reg)) begin
                res_hw = OFFSET_W'(total);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.finish) begin
            m_tdata_reg <= {6'd0, res_st, res_hw, res_off};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // status to the sequencer
    always_comb begin
        sts.clear_req = clear_reg;
        sts.full      = (count_reg >= MAX_CNT);
        sts.scan_done = !k_more && !pending_reg;
        sts.j_more    = (j_reg < count_reg);
        sts.skip      = !hit_j_reg || (found_reg && (cand_reg >= best_reg));
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule

[src/lifetime_aware_first_fit_packer_unit.sv]
// a request scans the whole table for offset 0, then fetches each stored region in turn and scans again
// for a live-overlapping region whose aligned end beats the lowest offset found so far
// each scan reads the table one entry a cycle through a single read port; clear and
// full-table requests go straight from the start state to the result with no scan
// one item at a time: the next transfer is taken the cycle after the result is written
// reset (aresetn low, synchronous) empties the table and zeroes the high-water size
module lifetime_aware_first_fit_packer_unit import lafp_pkg::*; #(
    parameter int MAX_REGIONS = 16,
    parameter int ADDR_BITS   = 32,
    parameter int PASS_BITS   = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // req_bytes[31:0], align_log2[36:32], life_start[44:37], life_end[52:45]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // offset[31:0], high_water[63:32], status[65:64]
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;
    logic finishing;

    // sequencer
    lafp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sts       (sts),
        .cmd       (cmd),
        .finishing (finishing)
    );

    // datapath
    lafp_dp #(
        .MAX_REGIONS (MAX_REGIONS),
        .ADDR_BITS   (ADDR_BITS),
        .PASS_BITS   (PASS_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd)) else $error("more than one datapath command");

    // one item in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second item taken while busy");

    // a result is only written into a free output slot
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (finishing && sts.out_free)) else $error("result overwrote output");

    // a written result shows up on the output
    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid) else $error("result lost");
`endif

endmodule

[bench/tb_top.sv]
// testbench of the lifetime-aware first-fit packer unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lafp_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] high_water;
        logic [31:0] offset;
    } placement_t;

    typedef struct {
        logic        op;
        logic [31:0] nbytes;
        logic [4:0]  alog;
        logic [7:0]  first;
        logic [7:0]  last;
        logic        has_exp;
        placement_t  exp;
    } request_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // predictor copy of the region table
    logic [63:0] slot_off [NUM_SLOTS];
    logic [63:0] slot_len [NUM_SLOTS];
    logic [7:0]  slot_first [NUM_SLOTS];
    logic [7:0]  slot_last [NUM_SLOTS];
    int          slot_count = 0;
    logic [63:0] mark = '0;

    placement_t pending_q[$];
    request_t   directed[$];
    int fail_count = 0;
    int send_idle = 8;
    int recv_idle = 88;
    int quiet_cycles = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    lifetime_aware_first_fit_packer_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic bit live_overlap(int i, logic [7:0] f, logic [7:0] l);
        return slot_first[i] <= l && f <= slot_last[i];
    endfunction

    function automatic bit byte_clash(logic [63:0] at, logic [63:0] n,
                                      logic [7:0] f, logic [7:0] l);
        for (int i = 0; i < slot_count; i++)
            if (live_overlap(i, f, l) && at < slot_off[i] + slot_len[i]
                && slot_off[i] < at + n)
                return 1'b1;
        return 1'b0;
    endfunction

    // first-fit placement, updates the predictor table
    function automatic placement_t place_region(request_t r);
        placement_t p;
        logic [63:0] best, cand, align, n;
        bit found;
        p = '0;
        if (r.op == OP_CLEAR) begin
            slot_count = 0;
            mark = '0;
            return p;
        end
        if (slot_count >= NUM_SLOTS) begin
            p.status = ST_FULL;
            p.high_water = mark[31:0];
            return p;
        end
        n = {32'd0, r.nbytes};
        align = 64'd1 << r.alog;
        best = '0;
        found = !byte_clash(64'd0, n, r.first, r.last);
        for (int i = 0; i < slot_count; i++) begin
            if (!live_overlap(i, r.first, r.last)) continue;
            cand = (slot_off[i] + slot_len[i] + align - 1) & ~(align - 1);
            if (found && cand >= best) continue;
            if (!byte_clash(cand, n, r.first, r.last)) begin
                best = cand;
                found = 1'b1;
            end
        end
        if (!found) best = '0;
        if (best + n > 64'hFFFF_FFFF) begin
            p.status = ST_OVERFLOW;
        end else begin
            slot_off[slot_count] = best;
            slot_len[slot_count] = n;
            slot_first[slot_count] = r.first;
            slot_last[slot_count] = r.last;
            slot_count++;
            if (best + n > mark) mark = best + n;
            p.offset = best[31:0];
        end
        p.high_water = mark[31:0];
        return p;
    endfunction

    function automatic request_t make_req(logic op, logic [31:0] n, logic [4:0] a,
                                          logic [7:0] f, logic [7:0] l);
        request_t r;
        r.op = op; r.nbytes = n; r.alog = a; r.first = f; r.last = l;
        r.has_exp = 1'b0; r.exp = '0;
        return r;
    endfunction

    function automatic request_t make_known(request_t r, logic [31:0] off,
                                            logic [31:0] hw, logic [1:0] st);
        r.has_exp = 1'b1;
        r.exp.offset = off; r.exp.high_water = hw; r.exp.status = st;
        return r;
    endfunction

    // append a row to the directed table
    function automatic void add_row(request_t r);
        directed.insert(directed.size(), r);
    endfunction

    // random request: mostly small regions in a busy pass window
    function automatic request_t rand_req();
        int k;
        logic [31:0] n;
        logic [7:0] f, l;
        k = $urandom_range(0, 99);
        if (k < 6) return make_req(OP_CLEAR, $urandom, 5'($urandom), 8'($urandom),
                                   8'($urandom));
        if (k < 10) n = $urandom;
        else if (k < 14) n = 32'hFFFF_FFFF - $urandom_range(0, 300);
        else if (k < 20) n = 32'd0;
        else n = $urandom_range(1, 4096);
        f = 8'($urandom_range(0, 40));
        l = 8'(f + $urandom_range(0, 30));
        if (k % 9 == 0) begin
            f = 8'($urandom);
            l = 8'($urandom);
        end
        return make_req(OP_RESERVE, n, 5'($urandom_range(0, 99) < 85 ?
                        $urandom_range(0, 12) : $urandom), f, l);
    endfunction

    // offer one transfer and wait for it to be taken
    task automatic send_req(request_t r);
        placement_t p;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {3'd0, r.last, r.first, r.alog, r.nbytes};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = place_region(r);
        if (r.has_exp && p != r.exp) begin
            $display("%0t predictor disagrees with table row: expected %h actual %h",
                     $time, r.exp, p);
            fail_count++;
        end
        pending_q.insert(pending_q.size(), r.has_exp ? r.exp : p);
    endtask

    // result side: random backpressure and checks
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    placement_t e, got;
                    e = pending_q.pop_front();
                    got = m_tdata[65:0];
                    if (got.offset !== e.offset)
                        $display("%0t offset mismatch: expected %h actual %h",
                                 $time, e.offset, got.offset);
                    if (got.high_water !== e.high_water)
                        $display("%0t high_water mismatch: expected %h actual %h",
                                 $time, e.high_water, got.high_water);
                    if (got.status !== e.status)
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, e.status, got.status);
                    if (got !== e) fail_count++;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        // directed table: extremes, error codes, special cases
        add_row(make_known(make_req(OP_RESERVE, 32'd100, 5'd0, 8'd0, 8'd255),
                           32'd0, 32'd100, ST_OK));
        add_row(make_known(make_req(OP_RESERVE, 32'd10, 5'd4, 8'd5, 8'd5),
                           32'd112, 32'd122, ST_OK));
        add_row(make_req(OP_RESERVE, 32'd0, 5'd31, 8'd5, 8'd9));
        add_row(make_req(OP_RESERVE, 32'd8, 5'd16, 8'd9, 8'd3));
        // the inverted-interval region above sits at 65536 and lifts the mark
        add_row(make_known(make_req(OP_RESERVE, 32'hFFFF_FFFF, 5'd0,
                           8'd0, 8'd0), 32'd0, 32'd65544, ST_OVERFLOW));
        add_row(make_known(make_req(OP_CLEAR, 32'hFFFF_FFFF, 5'd31,
                           8'd255, 8'd255), 32'd0, 32'd0, ST_OK));
        add_row(make_known(make_req(OP_RESERVE, 32'hFFFF_FFFF, 5'd0,
                           8'd255, 8'd255), 32'd0, 32'hFFFF_FFFF, ST_OK));
        add_row(make_known(make_req(OP_CLEAR, 32'd0, 5'd0, 8'd0, 8'd0),
                           32'd0, 32'd0, ST_OK));
        for (int i = 0; i < 16; i++)
            add_row(make_req(OP_RESERVE, 32'd64 + i, 5'(i % 7),
                             8'(i * 3), 8'(i * 3 + 10)));
        // table full: high-water left by the sixteen fills
        add_row(make_known(make_req(OP_RESERVE, 32'd1, 5'd0, 8'd200, 8'd201),
                           32'd0, 32'd342, ST_FULL));
        for (int i = 0; i < 16; i++) directed[8 + i].exp = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) send_req(directed[i]);
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin send_idle = 88; recv_idle = 8; end
            if (phase == 2) begin send_idle = 0; recv_idle = 0; end
            repeat (215) send_req(rand_req());
        end
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (fail_count == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

endmodule

[sim.f]
src/lafp_pkg.sv
src/lafp_ctrl.sv
src/lafp_dp.sv
src/lifetime_aware_first_fit_packer_unit.sv
bench/tb_top.sv
